// ===== hdl/tgadec_pkg.sv =====
package tgadec_pkg;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_HEADER,
    PH_SKIP,
    PH_PIXELS
  } phase_t;

  typedef enum logic [1:0] {
    KIND_HEADER     = 2'd0,
    KIND_RUN        = 2'd1,
    KIND_BAD_TYPE   = 2'd2,
    KIND_BAD_FORMAT = 2'd3
  } kind_t;

  localparam logic [4:0] HP_ID_LEN    = 5'd0;
  localparam logic [4:0] HP_CMAP_TYPE = 5'd1;
  localparam logic [4:0] HP_IMG_TYPE  = 5'd2;
  localparam logic [4:0] HP_WIDTH_LO  = 5'd12;
  localparam logic [4:0] HP_WIDTH_HI  = 5'd13;
  localparam logic [4:0] HP_HEIGHT_LO = 5'd14;
  localparam logic [4:0] HP_HEIGHT_HI = 5'd15;
  localparam logic [4:0] HP_DEPTH     = 5'd16;
  localparam logic [4:0] HP_LAST      = 5'd17;

  localparam logic [7:0] TGA_TYPE_RAW = 8'd2;
  localparam logic [7:0] TGA_TYPE_RLE = 8'd10;
  localparam logic [7:0] TGA_DEPTH_24 = 8'd24;
  localparam logic [7:0] TGA_DEPTH_32 = 8'd32;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  count;
    logic [15:0] width;
    logic [15:0] height;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic full;
  } fifo_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } fifo_rd_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [15:0] row;
    logic [15:0] column;
    logic [7:0]  run_length;
    logic        image_done;
    logic [15:0] image_width;
    logic [15:0] image_height;
  } result_t;

endpackage

// ===== hdl/tgadec_front.sv =====
module tgadec_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                start_of_file,
  input  logic                full,
  output logic                push,
  output tgadec_pkg::cmd_t    cmd
);

  tgadec_pkg::phase_t phase, phase_next, ph;
  logic [4:0]  hdr_pos, hdr_pos_next, pos;
  logic [7:0]  id_len, id_len_next;
  logic [7:0]  skip_left, skip_left_next;
  logic        compressed, compressed_next;
  logic        four_byte, four_byte_next;
  logic        type_bad, type_bad_next, tb;
  logic        format_bad, format_bad_next, fb;
  logic [15:0] width, width_next, w;
  logic [15:0] height, height_next, h;
  logic [7:0]  packet_left, packet_left_next;
  logic        packet_is_run, packet_is_run_next;
  logic [1:0]  byte_idx, byte_idx_next;
  logic [1:0]  need_last;
  logic [7:0]  blue, blue_next, green, green_next, red, red_next;
  logic        accept;

  assign in_ready  = !full;
  assign accept    = in_valid && in_ready;
  assign ph        = start_of_file ? tgadec_pkg::PH_HEADER : phase;
  assign pos       = start_of_file ? 5'd0 : hdr_pos;
  assign tb        = start_of_file ? 1'b0 : type_bad;
  assign fb        = start_of_file ? 1'b0 : format_bad;
  assign w         = start_of_file ? 16'd0 : width;
  assign h         = start_of_file ? 16'd0 : height;
  assign need_last = four_byte ? 2'd3 : 2'd2;

  always_comb begin
    phase_next         = phase;
    hdr_pos_next       = hdr_pos;
    id_len_next        = id_len;
    skip_left_next     = skip_left;
    compressed_next    = compressed;
    four_byte_next     = four_byte;
    type_bad_next      = type_bad;
    format_bad_next    = format_bad;
    width_next         = width;
    height_next        = height;
    packet_left_next   = packet_left;
    packet_is_run_next = packet_is_run;
    byte_idx_next      = byte_idx;
    blue_next          = blue;
    green_next         = green;
    red_next           = red;
    push               = 1'b0;
    cmd                = '0;
    if (accept) begin
      phase_next      = ph;
      hdr_pos_next    = pos;
      type_bad_next   = tb;
      format_bad_next = fb;
      width_next      = w;
      height_next     = h;
      unique case (ph)
        tgadec_pkg::PH_HEADER: begin
          unique case (pos)
            tgadec_pkg::HP_ID_LEN: id_len_next = data_byte;
            tgadec_pkg::HP_CMAP_TYPE: begin
              if (data_byte != 8'd0) format_bad_next = 1'b1;
            end
            tgadec_pkg::HP_IMG_TYPE: begin
              compressed_next = (data_byte == tgadec_pkg::TGA_TYPE_RLE);
              type_bad_next   = !(data_byte == tgadec_pkg::TGA_TYPE_RAW ||
                                  data_byte == tgadec_pkg::TGA_TYPE_RLE);
            end
            tgadec_pkg::HP_WIDTH_LO:  width_next[7:0]   = data_byte;
            tgadec_pkg::HP_WIDTH_HI:  width_next[15:8]  = data_byte;
            tgadec_pkg::HP_HEIGHT_LO: height_next[7:0]  = data_byte;
            tgadec_pkg::HP_HEIGHT_HI: height_next[15:8] = data_byte;
            tgadec_pkg::HP_DEPTH: begin
              four_byte_next = (data_byte == tgadec_pkg::TGA_DEPTH_32);
              if (data_byte != tgadec_pkg::TGA_DEPTH_24 &&
                  data_byte != tgadec_pkg::TGA_DEPTH_32) begin
                format_bad_next = 1'b1;
              end
            end
            default: ;
          endcase
          if (pos != tgadec_pkg::HP_LAST) begin
            hdr_pos_next = 5'(pos + 5'd1);
          end else begin
            push = 1'b1;
            if (tb) begin
              cmd.kind   = tgadec_pkg::KIND_BAD_TYPE;
              phase_next = tgadec_pkg::PH_IDLE;
            end else if (fb) begin
              cmd.kind   = tgadec_pkg::KIND_BAD_FORMAT;
              phase_next = tgadec_pkg::PH_IDLE;
            end else begin
              cmd.kind           = tgadec_pkg::KIND_HEADER;
              cmd.width          = w;
              cmd.height         = h;
              packet_left_next   = 8'd0;
              packet_is_run_next = 1'b0;
              byte_idx_next      = 2'd0;
              skip_left_next     = id_len;
              if (w == 16'd0 || h == 16'd0) begin
                phase_next = tgadec_pkg::PH_IDLE;
              end else if (id_len != 8'd0) begin
                phase_next = tgadec_pkg::PH_SKIP;
              end else begin
                phase_next = tgadec_pkg::PH_PIXELS;
              end
            end
          end
        end
        tgadec_pkg::PH_SKIP: begin
          skip_left_next = 8'(skip_left - 8'd1);
          if (skip_left == 8'd1) phase_next = tgadec_pkg::PH_PIXELS;
        end
        tgadec_pkg::PH_PIXELS: begin
          if (compressed && packet_left == 8'd0) begin
            packet_left_next   = {1'b0, data_byte[6:0]} + 8'd1;
            packet_is_run_next = data_byte[7];
          end else begin
            unique case (byte_idx)
              2'd0: blue_next  = data_byte;
              2'd1: green_next = data_byte;
              2'd2: red_next   = data_byte;
              default: ;
            endcase
            if (byte_idx != need_last) begin
              byte_idx_next = 2'(byte_idx + 2'd1);
            end else begin
              push          = 1'b1;
              byte_idx_next = 2'd0;
              cmd.kind      = tgadec_pkg::KIND_RUN;
              cmd.red       = (byte_idx == 2'd2) ? data_byte : red;
              cmd.green     = green;
              cmd.blue      = blue;
              cmd.alpha     = four_byte ? data_byte : tgadec_pkg::ALPHA_OPAQUE;
              if (compressed && packet_is_run) begin
                cmd.count        = packet_left;
                packet_left_next = 8'd0;
              end else begin
                cmd.count = 8'd1;
                if (compressed) packet_left_next = 8'(packet_left - 8'd1);
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= tgadec_pkg::PH_IDLE;
      hdr_pos       <= '0;
      id_len        <= '0;
      skip_left     <= '0;
      compressed    <= 1'b0;
      four_byte     <= 1'b0;
      type_bad      <= 1'b0;
      format_bad    <= 1'b0;
      width         <= '0;
      height        <= '0;
      packet_left   <= '0;
      packet_is_run <= 1'b0;
      byte_idx      <= '0;
    end else begin
      phase         <= phase_next;
      hdr_pos       <= hdr_pos_next;
      id_len        <= id_len_next;
      skip_left     <= skip_left_next;
      compressed    <= compressed_next;
      four_byte     <= four_byte_next;
      type_bad      <= type_bad_next;
      format_bad    <= format_bad_next;
      width         <= width_next;
      height        <= height_next;
      packet_left   <= packet_left_next;
      packet_is_run <= packet_is_run_next;
      byte_idx      <= byte_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    blue  <= blue_next;
    green <= green_next;
    red   <= red_next;
  end

  // The skip phase is entered only with a nonzero ID length.
  a_skip_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == tgadec_pkg::PH_SKIP |-> skip_left != 8'd0)
    else $error("skip phase with empty ID counter");

  // The header counter never runs past the last header byte.
  a_hdr_pos_range: assert property (@(posedge clk) disable iff (rst)
    hdr_pos <= tgadec_pkg::HP_LAST)
    else $error("header position out of range");

  // Pixel bytes are only counted up to the pixel size.
  a_byte_idx: assert property (@(posedge clk) disable iff (rst)
    !four_byte && phase == tgadec_pkg::PH_PIXELS |-> byte_idx != 2'd3)
    else $error("byte index past a three byte pixel");

endmodule

// ===== hdl/tgadec_fifo.sv =====
module tgadec_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  tgadec_pkg::cmd_t     wr_data,
  input  logic                 pop,
  output tgadec_pkg::cmd_t     rd_data,
  output tgadec_pkg::fifo_wr_t wr_status,
  output tgadec_pkg::fifo_rd_t rd_status
);

  tgadec_pkg::cmd_t                  entries [tgadec_pkg::FIFO_DEPTH];
  logic [tgadec_pkg::FIFO_AW-1:0]    wr_ptr, rd_ptr;
  logic [tgadec_pkg::FIFO_CW-1:0]    count;
  logic                              full, empty;

  localparam logic [tgadec_pkg::FIFO_AW-1:0] PtrLast =
    tgadec_pkg::FIFO_AW'(tgadec_pkg::FIFO_DEPTH - 1);
  localparam logic [tgadec_pkg::FIFO_CW-1:0] CountFull =
    tgadec_pkg::FIFO_CW'(tgadec_pkg::FIFO_DEPTH);

  assign full            = (count == CountFull);
  assign empty           = (count == '0);
  assign rd_data         = entries[rd_ptr];
  assign wr_status.push  = push;
  assign wr_status.full  = full;
  assign rd_status.pop   = pop;
  assign rd_status.empty = empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PtrLast) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == PtrLast) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= wr_data;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from an empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CountFull)
    else $error("queue count out of range");

endmodule

// ===== hdl/tgadec_back.sv =====
module tgadec_back (
  input  logic                 clk,
  input  logic                 rst,
  input  tgadec_pkg::cmd_t     cmd,
  input  logic                 empty,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output tgadec_pkg::result_t  res
);

  logic                active;
  logic                busy;
  logic [15:0]         row, col, width;
  logic [31:0]         rem, rem_after;
  logic [16:0]         acc, sum;
  logic [7:0]          n_eff;
  logic                clip;
  logic                emit;
  tgadec_pkg::result_t res_next;

  assign pop       = !empty && !busy && (!out_valid || out_ready);
  assign clip      = {24'd0, cmd.count} > rem;
  assign n_eff     = clip ? rem[7:0] : cmd.count;
  assign rem_after = rem - {24'd0, n_eff};
  assign sum       = {1'b0, col} + {9'd0, n_eff};
  assign emit      = pop && (cmd.kind != tgadec_pkg::KIND_RUN || active);

  always_comb begin
    res_next      = '0;
    res_next.kind = cmd.kind;
    if (cmd.kind == tgadec_pkg::KIND_HEADER) begin
      res_next.image_width  = cmd.width;
      res_next.image_height = cmd.height;
    end else if (cmd.kind == tgadec_pkg::KIND_RUN) begin
      res_next.red        = cmd.red;
      res_next.green      = cmd.green;
      res_next.blue       = cmd.blue;
      res_next.alpha      = cmd.alpha;
      res_next.row        = row;
      res_next.column     = col;
      res_next.run_length = n_eff;
      res_next.image_done = (rem_after == 32'd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      active    <= 1'b0;
      busy      <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (busy) begin
        if (acc >= {1'b0, width}) begin
          acc <= acc - {1'b0, width};
          row <= row - 16'd1;
        end else begin
          col  <= acc[15:0];
          busy <= 1'b0;
        end
      end
      if (pop) begin
        unique case (cmd.kind)
          tgadec_pkg::KIND_HEADER: begin
            active <= (cmd.width != 16'd0) && (cmd.height != 16'd0);
            row    <= cmd.height - 16'd1;
            col    <= 16'd0;
            width  <= cmd.width;
            rem    <= {16'd0, cmd.width} * {16'd0, cmd.height};
          end
          tgadec_pkg::KIND_RUN: begin
            if (active) begin
              rem <= rem_after;
              if (rem_after == 32'd0) begin
                active <= 1'b0;
              end else if (sum < {1'b0, width}) begin
                col <= sum[15:0];
              end else begin
                busy <= 1'b1;
                acc  <= sum;
              end
            end
          end
          tgadec_pkg::KIND_BAD_TYPE, tgadec_pkg::KIND_BAD_FORMAT: begin
            active <= 1'b0;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) res <= res_next;
  end

  a_busy_no_pop: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pop)
    else $error("command taken while the position is still wrapping");

  a_busy_active: assert property (@(posedge clk) disable iff (rst)
    busy |-> active && rem != 32'd0)
    else $error("wrapping with no pixels left in the image");

  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.kind == tgadec_pkg::KIND_RUN |-> res.run_length != 8'd0)
    else $error("empty pixel run");

endmodule

// ===== hdl/tga_image_stream_decoder.sv =====
// Streaming TGA decoder for uncompressed (type 2) and run-length (type 10) images
// in 24-bit BGR or 32-bit BGRA. It takes one file byte per item and returns at
// most one result per byte: a header report with the image size, an error report
// for an unsupported type, depth or colormap, or an RGBA pixel run with the
// bottom-up row and the column where it starts. Assert start_of_file on the first
// header byte of every file. The byte parser accepts one byte per cycle and feeds
// a four-entry command queue; the run placement unit behind it takes one command
// per cycle while not busy and the result side can take one. A run that crosses
// rows keeps it busy as it steps down a row per boundary and settles the column,
// so narrow images with long runs can hold off input while the queue is full.
module tga_image_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        start_of_file,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [15:0] row,
  output logic [15:0] column,
  output logic [7:0]  run_length,
  output logic        image_done,
  output logic [15:0] image_width,
  output logic [15:0] image_height
);

  tgadec_pkg::cmd_t     wr_cmd, rd_cmd;
  tgadec_pkg::fifo_wr_t wr_status;
  tgadec_pkg::fifo_rd_t rd_status;
  tgadec_pkg::result_t  res;
  logic                 push, pop;

  tgadec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .start_of_file (start_of_file),
    .full          (wr_status.full),
    .push          (push),
    .cmd           (wr_cmd)
  );

  tgadec_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_data   (wr_cmd),
    .pop       (pop),
    .rd_data   (rd_cmd),
    .wr_status (wr_status),
    .rd_status (rd_status)
  );

  tgadec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (rd_cmd),
    .empty     (rd_status.empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign kind         = res.kind;
  assign red          = res.red;
  assign green        = res.green;
  assign blue         = res.blue;
  assign alpha        = res.alpha;
  assign row          = res.row;
  assign column       = res.column;
  assign run_length   = res.run_length;
  assign image_done   = res.image_done;
  assign image_width  = res.image_width;
  assign image_height = res.image_height;

endmodule

// ===== tb/tb_tga_image_stream_decoder.sv =====
module tb_tga_image_stream_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET = 950;
  localparam int LONG_HOLD   = 400;
  localparam int DRAIN_WAIT  = 1000;

  class tga_scoreboard;
    tgadec_pkg::phase_t  phase;
    bit [4:0]            hdr_pos;
    bit [7:0]            id_len;
    bit [7:0]            skip_left;
    bit [7:0]            packet_left;
    bit                  rle;
    bit                  four;
    bit                  type_bad;
    bit                  format_bad;
    bit                  packet_is_run;
    bit [15:0]           width;
    bit [15:0]           height;
    bit [15:0]           cur_row;
    bit [15:0]           cur_col;
    bit [1:0]            pix_idx;
    bit [23:0]           pix_bytes;
    tgadec_pkg::result_t expected_q[$];
    int                  errors;
    int                  files;
    int                  headers;
    int                  runs;
    int                  bad_reports;
    int                  images_done;

    function new();
      phase = tgadec_pkg::PH_IDLE;
    endfunction

    // Returns 1 when the byte is consumed by the parser rather than dropped.
    function bit note_byte(bit [7:0] d, bit sof);
      tgadec_pkg::result_t r;
      bit                  used;
      bit                  have;
      int unsigned         need;
      int unsigned         n;
      longint unsigned     remaining;
      r = '0;
      have = 1'b0;
      if (sof) begin
        phase = tgadec_pkg::PH_HEADER;
        hdr_pos = '0;
        type_bad = 1'b0;
        format_bad = 1'b0;
        width = '0;
        height = '0;
        files++;
      end
      used = (phase != tgadec_pkg::PH_IDLE);
      case (phase)
        tgadec_pkg::PH_HEADER: begin
          case (hdr_pos)
            tgadec_pkg::HP_ID_LEN: id_len = d;
            tgadec_pkg::HP_CMAP_TYPE: if (d != 8'd0) format_bad = 1'b1;
            tgadec_pkg::HP_IMG_TYPE: begin
              rle = (d == tgadec_pkg::TGA_TYPE_RLE);
              type_bad = !(d == tgadec_pkg::TGA_TYPE_RAW || d == tgadec_pkg::TGA_TYPE_RLE);
            end
            tgadec_pkg::HP_WIDTH_LO: width = {8'h00, d};
            tgadec_pkg::HP_WIDTH_HI: width = width | {d, 8'h00};
            tgadec_pkg::HP_HEIGHT_LO: height = {8'h00, d};
            tgadec_pkg::HP_HEIGHT_HI: height = height | {d, 8'h00};
            tgadec_pkg::HP_DEPTH: begin
              four = (d == tgadec_pkg::TGA_DEPTH_32);
              if (d != tgadec_pkg::TGA_DEPTH_24 && d != tgadec_pkg::TGA_DEPTH_32)
                format_bad = 1'b1;
            end
            default: ;
          endcase
          if (hdr_pos < tgadec_pkg::HP_LAST) begin
            hdr_pos++;
          end else begin
            have = 1'b1;
            phase = tgadec_pkg::PH_IDLE;
            if (type_bad) begin
              r.kind = tgadec_pkg::KIND_BAD_TYPE;
            end else if (format_bad) begin
              r.kind = tgadec_pkg::KIND_BAD_FORMAT;
            end else begin
              r.kind = tgadec_pkg::KIND_HEADER;
              r.image_width = width;
              r.image_height = height;
              cur_row = height - 16'd1;
              cur_col = '0;
              packet_left = '0;
              packet_is_run = 1'b0;
              pix_idx = '0;
              pix_bytes = '0;
              skip_left = id_len;
              if (width != 16'd0 && height != 16'd0)
                phase = (skip_left != 8'd0) ? tgadec_pkg::PH_SKIP : tgadec_pkg::PH_PIXELS;
            end
          end
        end
        tgadec_pkg::PH_SKIP: begin
          skip_left--;
          if (skip_left == 8'd0) phase = tgadec_pkg::PH_PIXELS;
        end
        tgadec_pkg::PH_PIXELS: begin
          if (rle && packet_left == 8'd0) begin
            packet_left = {1'b0, d[6:0]} + 8'd1;
            packet_is_run = d[7];
          end else begin
            need = four ? 4 : 3;
            if (pix_idx == 2'd0) pix_bytes = '0;
            if (pix_idx < 3) pix_bytes[8*pix_idx +: 8] = d;
            if (pix_idx + 1 < need) begin
              pix_idx++;
            end else begin
              pix_idx = '0;
              if (rle && packet_is_run) begin
                n = packet_left;
                packet_left = '0;
              end else begin
                n = 1;
                if (rle) packet_left--;
              end
              remaining = 64'(cur_row) * 64'(width) + 64'(width - cur_col);
              if (64'(n) > remaining) n = 32'(remaining);
              remaining -= 64'(n);
              have = 1'b1;
              r.kind = tgadec_pkg::KIND_RUN;
              r.red = pix_bytes[23:16];
              r.green = pix_bytes[15:8];
              r.blue = pix_bytes[7:0];
              r.alpha = four ? d : tgadec_pkg::ALPHA_OPAQUE;
              r.row = cur_row;
              r.column = cur_col;
              r.run_length = n[7:0];
              r.image_done = (remaining == 0);
              if (remaining == 0) begin
                phase = tgadec_pkg::PH_IDLE;
              end else begin
                cur_row = 16'((remaining - 1) / 64'(width));
                cur_col = 16'(64'(width) - (remaining - 64'(cur_row) * 64'(width)));
              end
            end
          end
        end
        default: ;
      endcase
      if (have) expected_q.push_back(r);
      return used;
    endfunction

    function void compare(string name, longint unsigned want, longint unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(tgadec_pkg::result_t got);
      tgadec_pkg::result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual kind %0d", $time, got.kind);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare("kind", want.kind, got.kind);
      compare("red", want.red, got.red);
      compare("green", want.green, got.green);
      compare("blue", want.blue, got.blue);
      compare("alpha", want.alpha, got.alpha);
      compare("row", want.row, got.row);
      compare("column", want.column, got.column);
      compare("run_length", want.run_length, got.run_length);
      compare("image_done", want.image_done, got.image_done);
      compare("image_width", want.image_width, got.image_width);
      compare("image_height", want.image_height, got.image_height);
      case (got.kind)
        tgadec_pkg::KIND_HEADER: headers++;
        tgadec_pkg::KIND_RUN: runs++;
        default: bad_reports++;
      endcase
      if (got.image_done) images_done++;
    endfunction
  endclass

  logic        clk;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        start_of_file = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [15:0] row;
  logic [15:0] column;
  logic [7:0]  run_length;
  logic        image_done;
  logic [15:0] image_width;
  logic [15:0] image_height;

  tga_scoreboard sb = new();
  int  sender_gap_pct = 0;
  int  receiver_stall_pct = 0;
  bit  hold_req = 1'b0;
  int  hold_count = 0;
  int  useful_bytes = 0;

  tga_image_stream_decoder uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .start_of_file(start_of_file),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .kind(kind),
    .red(red),
    .green(green),
    .blue(blue),
    .alpha(alpha),
    .row(row),
    .column(column),
    .run_length(run_length),
    .image_done(image_done),
    .image_width(image_width),
    .image_height(image_height)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    tgadec_pkg::result_t got;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        got.kind = tgadec_pkg::kind_t'(kind);
        got.red = red;
        got.green = green;
        got.blue = blue;
        got.alpha = alpha;
        got.row = row;
        got.column = column;
        got.run_length = run_length;
        got.image_done = image_done;
        got.image_width = image_width;
        got.image_height = image_height;
        sb.check_result(got);
      end
      if (hold_req && hold_count < LONG_HOLD) begin
        out_ready <= 1'b0;
        hold_count++;
      end else begin
        out_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  function automatic bit [7:0] rand_byte();
    case ($urandom_range(4))
      0: return 8'h00;
      1: return 8'hff;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic send_byte(bit [7:0] d, bit sof);
    while ($urandom_range(99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= d;
    start_of_file <= sof;
    do @(posedge clk); while (!in_ready);
    if (sb.note_byte(d, sof)) useful_bytes++;
  endtask

  task automatic send_header(bit [7:0] id, bit [7:0] cmap, bit [7:0] itype,
                             int unsigned w, int unsigned h, bit [7:0] depth);
    send_byte(id, 1'b1);
    send_byte(cmap, 1'b0);
    send_byte(itype, 1'b0);
    repeat (9) send_byte(rand_byte(), 1'b0);
    send_byte(w[7:0], 1'b0);
    send_byte(w[15:8], 1'b0);
    send_byte(h[7:0], 1'b0);
    send_byte(h[15:8], 1'b0);
    send_byte(depth, 1'b0);
    send_byte(rand_byte(), 1'b0);
  endtask

  task automatic send_pixel(bit four);
    repeat (four ? 4 : 3) send_byte(rand_byte(), 1'b0);
  endtask

  task automatic send_image(bit rle, bit four, int unsigned w, int unsigned h,
                            bit [7:0] id, int unsigned budget, bit long_runs);
    int unsigned left;
    int unsigned cnt;
    int unsigned k;
    bit          run;
    send_header(id, 8'd0, rle ? tgadec_pkg::TGA_TYPE_RLE : tgadec_pkg::TGA_TYPE_RAW, w, h,
                four ? tgadec_pkg::TGA_DEPTH_32 : tgadec_pkg::TGA_DEPTH_24);
    repeat (id) send_byte(rand_byte(), 1'b0);
    left = budget;
    while (left > 0) begin
      if (rle) begin
        run = long_runs ? 1'b1 : 1'($urandom_range(1));
        if (long_runs) cnt = $urandom_range(127, 48);
        else cnt = ($urandom_range(9) < 6) ? $urandom_range(3) : $urandom_range(127);
        send_byte({run, cnt[6:0]}, 1'b0);
        cnt++;
        if (run) begin
          send_pixel(four);
          left = (cnt >= left) ? 0 : left - cnt;
        end else begin
          for (k = 0; k < cnt && left > 0; k++) begin
            send_pixel(four);
            left--;
          end
        end
      end else begin
        send_pixel(four);
        left--;
      end
    end
  endtask

  task automatic send_random_file();
    int unsigned w;
    int unsigned h;
    int unsigned budget;
    bit          rle;
    bit          four;
    bit          tall;
    bit [7:0]    id;
    bit [7:0]    itype;
    bit [7:0]    depth;
    bit [7:0]    cmap;
    int          sel;
    sel = $urandom_range(99);
    rle = $urandom_range(1);
    four = $urandom_range(1);
    if (sel < 60) begin
      tall = ($urandom_range(5) == 0);
      if (tall) begin
        rle = 1'b1;
        w = $urandom_range(3, 1);
        h = $urandom_range(200, 20);
      end else begin
        w = $urandom_range(5, 1);
        h = $urandom_range(4, 1);
      end
      case ($urandom_range(39))
        0: id = 8'($urandom_range(255));
        1, 2, 3, 4, 5, 6, 7, 8, 9: id = 8'($urandom_range(4, 1));
        default: id = 8'd0;
      endcase
      budget = w * h;
      if ($urandom_range(9) == 0) budget = $urandom_range(w * h - 1);
      send_image(rle, four, w, h, id, budget, tall);
      if ($urandom_range(6) == 0) repeat ($urandom_range(3, 1)) send_byte(rand_byte(), 1'b0);
    end else if (sel < 70) begin
      w = ($urandom_range(4) == 0) ? 65535 : $urandom_range(65535, 1);
      h = ($urandom_range(4) == 0) ? 65535 : $urandom_range(65535, 1);
      send_image(rle, four, w, h, 8'd0, $urandom_range(6, 1), $urandom_range(1));
    end else if (sel < 80) begin
      itype = rle ? tgadec_pkg::TGA_TYPE_RLE : tgadec_pkg::TGA_TYPE_RAW;
      depth = four ? tgadec_pkg::TGA_DEPTH_32 : tgadec_pkg::TGA_DEPTH_24;
      cmap = 8'd0;
      case ($urandom_range(3))
        0: begin
          do itype = rand_byte();
          while (itype == tgadec_pkg::TGA_TYPE_RAW || itype == tgadec_pkg::TGA_TYPE_RLE);
        end
        1: cmap = 8'($urandom_range(255, 1));
        2: begin
          do depth = rand_byte();
          while (depth == tgadec_pkg::TGA_DEPTH_24 || depth == tgadec_pkg::TGA_DEPTH_32);
        end
        default: begin
          do itype = rand_byte();
          while (itype == tgadec_pkg::TGA_TYPE_RAW || itype == tgadec_pkg::TGA_TYPE_RLE);
          cmap = 8'($urandom_range(255, 1));
        end
      endcase
      send_header(8'($urandom_range(3)), cmap, itype, $urandom_range(4, 1),
                  $urandom_range(4, 1), depth);
      repeat ($urandom_range(5)) send_byte(rand_byte(), 1'b0);
    end else if (sel < 88) begin
      w = $urandom_range(1) ? 0 : $urandom_range(65535);
      h = (w == 0) ? $urandom_range(65535) : 0;
      send_header(8'($urandom_range(3)), 8'd0,
                  rle ? tgadec_pkg::TGA_TYPE_RLE : tgadec_pkg::TGA_TYPE_RAW, w, h,
                  four ? tgadec_pkg::TGA_DEPTH_32 : tgadec_pkg::TGA_DEPTH_24);
      repeat ($urandom_range(4)) send_byte(rand_byte(), 1'b0);
    end else if (sel < 96) begin
      send_byte(rand_byte(), 1'b1);
      repeat ($urandom_range(15)) send_byte(rand_byte(), 1'b0);
    end else begin
      repeat ($urandom_range(6, 2)) send_byte(rand_byte(), 1'b0);
    end
  endtask

  initial begin
    int random_start;
    int quarter;
    rst <= 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_header(8'd2, 8'd0, tgadec_pkg::TGA_TYPE_RLE, 3, 2, tgadec_pkg::TGA_DEPTH_32);
    send_byte(8'hff, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h81, 1'b0);
    repeat (4) send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    repeat (4) send_byte(8'hff, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'h7f, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'hfe, 1'b0);
    send_byte(8'h55, 1'b0);
    send_image(1'b0, 1'b0, 2, 2, 8'd0, 1, 1'b0);
    send_byte(8'haa, 1'b0);
    send_image(1'b0, 1'b0, 2, 2, 8'd0, 4, 1'b0);
    send_header(8'd0, 8'd1, 8'd3, 1, 1, 8'd16);
    send_byte(8'h0a, 1'b0);
    send_header(8'd0, 8'd0, tgadec_pkg::TGA_TYPE_RAW, 1, 1, 8'd16);
    send_header(8'd0, 8'd1, tgadec_pkg::TGA_TYPE_RLE, 1, 1, tgadec_pkg::TGA_DEPTH_24);
    send_header(8'd0, 8'd0, tgadec_pkg::TGA_TYPE_RAW, 0, 5, tgadec_pkg::TGA_DEPTH_24);
    send_byte(8'h01, 1'b0);
    send_header(8'd0, 8'd0, tgadec_pkg::TGA_TYPE_RLE, 7, 0, tgadec_pkg::TGA_DEPTH_32);
    send_image(1'b1, 1'b1, 1, 1, 8'd255, 1, 1'b0);
    send_image(1'b1, 1'b0, 65535, 65535, 8'd0, 3, 1'b1);

    // Hold the result side off while a narrow image with long runs streams in.
    hold_req = 1'b1;
    send_image(1'b1, 1'b0, 1, 300, 8'd0, 300, 1'b1);

    random_start = useful_bytes;
    while (useful_bytes < ITEM_TARGET) begin
      quarter = (useful_bytes - random_start) * 4 / (ITEM_TARGET - random_start);
      case (quarter)
        0: begin
          sender_gap_pct = 0;
          receiver_stall_pct = 0;
        end
        1: begin
          sender_gap_pct = 47;
          receiver_stall_pct = 0;
        end
        2: begin
          sender_gap_pct = 0;
          receiver_stall_pct = 47;
        end
        default: begin
          sender_gap_pct = 31;
          receiver_stall_pct = 31;
        end
      endcase
      send_random_file();
    end
    in_valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("Sent %0d parsed bytes over %0d file starts, with and without idling on both sides.",
             useful_bytes, sb.files);
    $display("Checked %0d headers, %0d pixel runs, %0d error reports, %0d finished images.",
             sb.headers, sb.runs, sb.bad_reports, sb.images_done);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
